// File: rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared widths, constants, codes and word types of the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned TrigW    = 16;
  localparam int unsigned WaitW    = 23;
  localparam int unsigned WidthW   = 19;
  localparam int unsigned DistW    = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 23;

  localparam int unsigned TicksPerUnitDef = 65;

  localparam logic [TrigW-1:0]  TrigTicksRst = 16'd221;
  localparam logic [WaitW-1:0]  EchoWaitRst  = 23'd5000000;
  localparam logic [WidthW-1:0] WidthLimRst  = 19'h40000;

  localparam logic [WidthW-1:0] MaxWidth = 19'h40000;
  localparam logic [DistW-1:0]  ErrDist  = 16'hFFFF;

  typedef enum logic [1:0] {
    PhIdle,
    PhTrig,
    PhWait,
    PhMeas
  } uer_phase_e;

  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StNoEcho = 2'd1,
    StTooFar = 2'd2
  } uer_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTrigTicks  = 2'd0,
    CfgEchoWait   = 2'd1,
    CfgWidthLimit = 2'd2
  } uer_cfg_idx_e;

  typedef struct packed {
    logic start_req;
    logic echo;
  } uer_in_t;

  typedef struct packed {
    logic               trig_level;
    logic               done_res;
    logic [DistW-1:0]   distance;
    logic [StatusW-1:0] status;
  } uer_out_t;

endpackage

// File: rtl/uer_div.sv
// ----------------------------------------------------------------------------
// Echo width to distance converter
// Divides the echo width count by a constant with a reciprocal multiply and
// saturates the quotient to the distance width.
// ----------------------------------------------------------------------------
module uer_div
  import uer_pkg::*;
#(
  parameter int unsigned TICKS_PER_UNIT = TicksPerUnitDef
) (
  input  logic [WidthW-1:0] count_i,
  output logic [DistW-1:0]  dist_o
);

  localparam int unsigned Shift  = WidthW + $clog2(TICKS_PER_UNIT);
  localparam int unsigned RecipW = WidthW + 1;
  localparam int unsigned ProdW  = WidthW + RecipW;
  localparam longint unsigned RecipVal =
      ((64'd1 << Shift) + TICKS_PER_UNIT - 1) / TICKS_PER_UNIT;

  logic [RecipW-1:0] recip;
  logic [ProdW-1:0]  prod;
  logic [ProdW-1:0]  quot;

  assign recip = RecipW'(RecipVal);
  assign prod  = ProdW'(count_i) * ProdW'(recip);
  assign quot  = prod >> Shift;

  always_comb begin
    if (|quot[ProdW-1:DistW]) begin
      dist_o = ErrDist;
    end else begin
      dist_o = quot[DistW-1:0];
    end
  end

endmodule

// File: rtl/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger and echo timing controller for a pulse-echo ranging sensor.
// ----------------------------------------------------------------------------
// Each input word is one timer tick carrying a start request and the sampled
// echo pin level. Every input word yields exactly one output word with the
// trigger pin level for that tick and, on the tick a measurement ends, the
// done flag, the distance and the status.
// Both channels use valid and stall. An input word is registered, then the
// control state and the result are computed in one pass into the output
// register. One word is taken every cycle unless stalled. A two-entry output
// buffer keeps input words flowing while a finished result is stalled; the
// input side stalls only when both output entries are full and an input word
// is waiting. Reset returns the controller to idle, clears all words in
// flight and loads the configuration registers with their default values.
// Configuration is written through a plain write port; the user must write
// it only while no word is in flight, and the block does not enforce this.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit
  import uer_pkg::*;
#(
  parameter int unsigned TICKS_PER_UNIT = TicksPerUnitDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  uer_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output uer_out_t            out_data_o
);

  logic [TrigW-1:0]  trig_ticks_q;
  logic [WaitW-1:0]  wait_lim_q;
  logic [WidthW-1:0] width_lim_q;
  logic [WidthW-1:0] eff_lim;

  logic    in_valid_q;
  uer_in_t in_q;

  uer_phase_e        phase_q, phase_d;
  logic [WaitW-1:0]  cnt_q, cnt_d;
  logic [WidthW-1:0] wc_q, wc_d;
  logic [WidthW-1:0] wc_inc;
  logic [DistW-1:0]  quot;
  uer_out_t          res;

  logic     out_valid_q, skid_valid_q;
  uer_out_t out_q, skid_q;
  logic     advance, out_take, in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TrigTicksRst;
      wait_lim_q   <= EchoWaitRst;
      width_lim_q  <= WidthLimRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTrigTicks:  trig_ticks_q <= cfg_data_i[TrigW-1:0];
        CfgEchoWait:   wait_lim_q   <= cfg_data_i[WaitW-1:0];
        CfgWidthLimit: width_lim_q  <= cfg_data_i[WidthW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_lim_q == '0) begin
      eff_lim = WidthW'(1);
    end else if (width_lim_q > MaxWidth) begin
      eff_lim = MaxWidth;
    end else begin
      eff_lim = width_lim_q;
    end
  end

  assign out_take   = out_valid_q & ~out_stall_i;
  assign advance    = in_valid_q & ~skid_valid_q;
  assign in_stall_o = in_valid_q & skid_valid_q;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  uer_div #(
    .TICKS_PER_UNIT(TICKS_PER_UNIT)
  ) u_div (
    .count_i(wc_q),
    .dist_o (quot)
  );

  assign wc_inc = wc_q + WidthW'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    wc_d    = wc_q;
    res     = '0;
    case (phase_q)
      PhIdle: begin
        if (in_q.start_req) begin
          wc_d           = '0;
          res.trig_level = 1'b1;
          if (trig_ticks_q <= TrigW'(1)) begin
            phase_d = PhWait;
            cnt_d   = '0;
          end else begin
            phase_d = PhTrig;
            cnt_d   = WaitW'(1);
          end
        end
      end
      PhTrig: begin
        res.trig_level = 1'b1;
        cnt_d          = cnt_q + WaitW'(1);
        if (cnt_d >= WaitW'(trig_ticks_q)) begin
          phase_d = PhWait;
          cnt_d   = '0;
        end
      end
      PhWait: begin
        if (in_q.echo) begin
          cnt_d = '0;
          wc_d  = WidthW'(1);
          if (eff_lim == WidthW'(1)) begin
            res.done_res = 1'b1;
            res.distance = ErrDist;
            res.status   = StTooFar;
            phase_d      = PhIdle;
          end else begin
            phase_d = PhMeas;
          end
        end else if (cnt_q >= wait_lim_q) begin
          res.done_res = 1'b1;
          res.distance = ErrDist;
          res.status   = StNoEcho;
          phase_d      = PhIdle;
          cnt_d        = '0;
        end else begin
          cnt_d = cnt_q + WaitW'(1);
        end
      end
      PhMeas: begin
        if (in_q.echo) begin
          wc_d = wc_inc;
          if (wc_inc >= eff_lim) begin
            res.done_res = 1'b1;
            res.distance = ErrDist;
            res.status   = StTooFar;
            phase_d      = PhIdle;
          end
        end else begin
          res.done_res = 1'b1;
          res.distance = quot;
          res.status   = StOk;
          phase_d      = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      wc_q    <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      wc_q    <= wc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (advance) begin
      out_valid_q <= 1'b1;
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (advance) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Output buffer holds a word behind an empty head.");

  a_trig_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhTrig) |-> (cnt_q != '0))
    else $error("Trigger phase entered with a zero tick count.");

  a_meas_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhMeas) |-> ((wc_q != '0) && (wc_q < eff_lim)))
    else $error("Echo width count outside the measurement range.");

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.done_res) |->
      ((out_data_o.distance == '0) && (out_data_o.status == StOk)))
    else $error("Distance or status set on a word that ends no measurement.");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Echo ranger testbench
// Drives timer ticks into the ranging controller and checks every output word
// against a cycle-free prediction of the trigger, wait and echo timing.
// Short directed cases cover zero lengths, start while busy and register
// extremes. Random measurements with random register settings follow, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  import uer_pkg::*;

  localparam int unsigned TicksPerUnit = TicksPerUnitDef;
  localparam int unsigned RandomWords  = 1100;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned MaxReports   = 100;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  uer_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  uer_out_t            out_data_o;

  ultrasonic_echo_ranger_unit #(
    .TICKS_PER_UNIT(TicksPerUnit)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  logic [TrigW-1:0]  trig_len  = TrigTicksRst;
  logic [WaitW-1:0]  wait_lim  = EchoWaitRst;
  logic [WidthW-1:0] width_lim = WidthLimRst;

  uer_phase_e        ranger_phase = PhIdle;
  logic [WaitW-1:0]  phase_cnt    = '0;
  logic [WidthW-1:0] width_cnt    = '0;

  uer_out_t    tick_results_q[$];
  int unsigned words_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  bit          idle_en      = 1'b1;
  bit          stall_en     = 1'b1;

  function automatic logic coin();
    return logic'($urandom_range(0, 1));
  endfunction

  task automatic advance_ranger(input uer_in_t w, output uer_out_t r);
    logic [WidthW-1:0] lim;
    int unsigned       quot;
    r   = '0;
    lim = (width_lim == '0) ? WidthW'(1) : width_lim;
    if (lim > MaxWidth) lim = MaxWidth;
    case (ranger_phase)
      PhIdle: begin
        if (w.start_req) begin
          width_cnt    = '0;
          phase_cnt    = WaitW'(1);
          r.trig_level = 1'b1;
          if (phase_cnt >= WaitW'(trig_len)) begin
            ranger_phase = PhWait;
            phase_cnt    = '0;
          end else begin
            ranger_phase = PhTrig;
          end
        end
      end
      PhTrig: begin
        r.trig_level = 1'b1;
        phase_cnt    = phase_cnt + WaitW'(1);
        if (phase_cnt >= WaitW'(trig_len)) begin
          ranger_phase = PhWait;
          phase_cnt    = '0;
        end
      end
      PhWait: begin
        if (w.echo) begin
          phase_cnt = '0;
          width_cnt = WidthW'(1);
          if (width_cnt >= lim) begin
            r.done_res   = 1'b1;
            r.distance   = ErrDist;
            r.status     = StTooFar;
            ranger_phase = PhIdle;
          end else begin
            ranger_phase = PhMeas;
          end
        end else if (phase_cnt >= wait_lim) begin
          r.done_res   = 1'b1;
          r.distance   = ErrDist;
          r.status     = StNoEcho;
          ranger_phase = PhIdle;
          phase_cnt    = '0;
        end else begin
          phase_cnt = phase_cnt + WaitW'(1);
        end
      end
      default: begin
        if (w.echo) begin
          width_cnt = width_cnt + WidthW'(1);
          if (width_cnt >= lim) begin
            r.done_res   = 1'b1;
            r.distance   = ErrDist;
            r.status     = StTooFar;
            ranger_phase = PhIdle;
          end
        end else begin
          quot         = width_cnt / TicksPerUnit;
          r.done_res   = 1'b1;
          r.distance   = (quot > ErrDist) ? ErrDist : DistW'(quot);
          r.status     = StOk;
          ranger_phase = PhIdle;
        end
      end
    endcase
  endtask

  // Called and returning at a falling edge.
  task automatic send_tick(input logic start, input logic echo_lvl);
    int unsigned gap;
    uer_in_t     w;
    uer_out_t    r;
    gap         = idle_en ? $urandom_range(0, 16) : 0;
    w.start_req = start;
    w.echo      = echo_lvl;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_ranger(w, r);
    tick_results_q.push_back(r);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgTrigTicks:  trig_len  = val[TrigW-1:0];
      CfgEchoWait:   wait_lim  = val[WaitW-1:0];
      CfgWidthLimit: width_lim = val[WidthW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tick_results_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_tick(coin(), coin());
  endtask

  task automatic run_measurement(input int unsigned low_ticks, input int unsigned high_ticks);
    int unsigned n;
    while (ranger_phase != PhIdle) send_tick(coin(), 1'b0);
    send_tick(1'b1, coin());
    while (ranger_phase == PhTrig) send_tick(coin(), coin());
    n = 0;
    while (ranger_phase == PhWait && n < low_ticks) begin
      send_tick(coin(), 1'b0);
      n++;
    end
    n = 0;
    while (ranger_phase != PhIdle && n < high_ticks) begin
      send_tick(coin(), 1'b1);
      n++;
    end
    if (ranger_phase != PhIdle) send_tick(coin(), 1'b0);
  endtask

  task automatic test_zero_lengths();
    write_reg(CfgSpare, 23'h7FFFFF);
    write_reg(CfgTrigTicks, 23'h7F0000);
    write_reg(CfgEchoWait, 23'd0);
    write_reg(CfgWidthLimit, 23'h780000);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_start_while_busy();
    write_reg(CfgTrigTicks, 23'd3);
    write_reg(CfgEchoWait, 23'd3);
    write_reg(CfgWidthLimit, 23'h7FFFF);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    repeat (4) send_tick(1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(CfgTrigTicks, 23'd65535);
    write_reg(CfgEchoWait, 23'h7FFFFF);
    write_reg(CfgWidthLimit, 23'd1);
    send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b1);
    wait_idle();
    write_reg(CfgTrigTicks, 23'd1);
    repeat (3) send_tick(1'b0, 1'b0);
    wait_idle();
    write_reg(CfgEchoWait, 23'd0);
    send_tick(1'b0, 1'b0);
    wait_idle();
    write_reg(CfgWidthLimit, 23'h40000);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_ranging();
    int unsigned first;
    int unsigned echo_len;
    logic [WidthW-1:0] lim;
    first = words_sent;
    // One measurement at the reset settings.
    write_reg(CfgTrigTicks, {7'($urandom), TrigTicksRst});
    write_reg(CfgEchoWait, EchoWaitRst);
    write_reg(CfgWidthLimit, {4'($urandom), WidthLimRst});
    idle_en  = 1'b0;
    stall_en = 1'b0;
    run_measurement($urandom_range(0, 20), $urandom_range(65, 200));
    while (words_sent - first < RandomWords) begin
      wait_idle();
      idle_en  = $urandom_range(0, 3) != 0;
      stall_en = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 5))
        0, 1:    lim = WidthW'($urandom_range(1, 24));
        2, 3:    lim = WidthW'($urandom_range(60, 250));
        4:       lim = MaxWidth;
        default: lim = '1;
      endcase
      write_reg(CfgTrigTicks, {7'($urandom), 16'($urandom_range(0, 5))});
      write_reg(CfgEchoWait, 23'($urandom_range(0, 12)));
      write_reg(CfgWidthLimit, {4'($urandom), lim});
      if (coin()) write_reg(CfgSpare, 23'($urandom));
      repeat ($urandom_range(3, 6)) begin
        if (words_sent - first < RandomWords) begin
          if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 4));
          echo_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 24)
                                                : $urandom_range(60, 200);
          run_measurement($urandom_range(0, wait_lim + 2), echo_len);
        end
      end
    end
    wait_idle();
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, tick_results_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = stall_en ? $urandom_range(0, 16) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    uer_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tick_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: unexpected output word, expected none, actual %h", $time,
                   out_data_o);
        end
      end else begin
        want = tick_results_q.pop_front();
        check_field("trig_level", 32'(want.trig_level), 32'(out_data_o.trig_level));
        check_field("done_res", 32'(want.done_res), 32'(out_data_o.done_res));
        check_field("distance", 32'(want.distance), 32'(out_data_o.distance));
        check_field("status", 32'(want.status), 32'(out_data_o.status));
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_zero_lengths();
    test_start_while_busy();
    test_register_extremes();
    test_random_ranging();
    repeat (16) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
